// ----- hw/rtl/ncds_pkg.sv -----
package ncds_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 24;

  localparam logic [30:0] GRAVITY_RESET = 31'd164528285;
  localparam logic [30:0] TOL_RESET     = 31'd0;
  localparam logic [7:0]  MAXIT_RESET   = 8'd64;

  // register indexes on the configuration port
  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_TOL     = 2'd1;
  localparam logic [1:0] REG_MAXIT   = 2'd2;

  typedef enum logic [1:0] {
    STAT_CONVERGED = 2'd0,
    STAT_LIMIT     = 2'd1,
    STAT_ZERO_DIV  = 2'd2
  } status_e;

endpackage

// ----- hw/rtl/ncds_if.sv -----
interface ncds_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] head;
  logic [31:0] flow;
  logic [31:0] width;
  logic [31:0] ref_depth;
  logic [31:0] start_guess;

  modport source (output valid, head, flow, width, ref_depth, start_guess, input ready);
  modport sink   (input valid, head, flow, width, ref_depth, start_guess, output ready);
  modport monitor(input valid, ready, head, flow, width, ref_depth, start_guess);
endinterface

interface ncds_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] root;
  logic [7:0]  iterations_used;
  logic [1:0]  status;

  modport source (output valid, root, iterations_used, status, input ready);
  modport sink   (input valid, root, iterations_used, status, output ready);
  modport monitor(input valid, ready, root, iterations_used, status);
endinterface

// ----- hw/rtl/newton_cubic_depth_solver.sv -----
// Newton solver for the depth cubic h^3 + A*h^2 + C in signed fixed point
// (FRAC_BITS fraction bits in a WORD_BITS word, Q8.24 by default). Each request
// item forms C = Q^2/(2*g*b^2) and A = H - C/h0^2 - h0, then runs Newton steps
// until the percent change drops below tolerance_percent or max_iterations
// steps are taken. One shared multiplier and one shared restoring divider
// (one quotient bit per cycle, WORD_BITS+FRAC_BITS bits) do all the work under
// a one-hot sequencer. The block takes one item at a time: ready is high only
// while idle, and the result holds until taken. All results saturate to the word
// range; a zero divisor returns status 2 with the current estimate.
module newton_cubic_depth_solver
  import ncds_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ncds_req_if.sink    req_i,
  ncds_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned NW  = W + F;
  localparam int unsigned MW  = 2 * W + F;
  localparam int unsigned CNW = $clog2(NW + 1);
  localparam int unsigned KW  = F + 7;
  localparam int unsigned LW  = W + 1 + KW;
  localparam int unsigned CW  = (LW > W + 31) ? LW : W + 31;

  localparam logic [W-1:0]  WMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic [MW-1:0] WMAX_M = MW'(WMAX_W);
  localparam logic signed [63:0] WMAX64 = 64'(WMAX_W);
  localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;
  localparam logic [KW-1:0] K100 = KW'(100) << F;

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_B2   = 21'h000002,
    S_DEN  = 21'h000004,
    S_H02  = 21'h000008,
    S_QQ   = 21'h000010,
    S_CLD  = 21'h000020,
    S_CRUN = 21'h000040,
    S_ALD  = 21'h000080,
    S_ARUN = 21'h000100,
    S_ACO  = 21'h000200,
    S_H2   = 21'h000400,
    S_AH   = 21'h000800,
    S_H3   = 21'h001000,
    S_AH2  = 21'h002000,
    S_FSUM = 21'h004000,
    S_NLD  = 21'h008000,
    S_NRUN = 21'h010000,
    S_UPD  = 21'h020000,
    S_CL   = 21'h040000,
    S_CR   = 21'h080000,
    S_DONE = 21'h100000
  } state_e;

  function automatic logic [W-1:0] mag_f(logic [W-1:0] a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic logic [W-1:0] sat_mag(logic [MW-1:0] m, logic neg);
    if (m > WMAX_M) return neg ? WMIN_W : WMAX_W;
    return neg ? W'(~m + 1'b1) : W'(m);
  endfunction

  function automatic logic [W-1:0] add_s(logic [W-1:0] a, logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN_W : WMAX_W;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_s(logic [W-1:0] a, logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN_W : WMAX_W;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mul_fx(logic [W-1:0] a, logic [W-1:0] b);
    logic [PW-1:0] p;
    p = PW'(mag_f(a)) * PW'(mag_f(b));
    return sat_mag(MW'(p >> F), a[W-1] ^ b[W-1]);
  endfunction

  function automatic logic [W-1:0] in_w(logic [31:0] x);
    logic signed [63:0] x64;
    x64 = 64'($signed(x));
    if (x64 > WMAX64) return WMAX_W;
    if (x64 < WMIN64) return WMIN_W;
    return W'(x64);
  endfunction

  function automatic logic [31:0] out32(logic [W-1:0] x);
    logic signed [63:0] x64;
    x64 = 64'($signed(x));
    if (x64 > 64'sd2147483647) return 32'h7fffffff;
    if (x64 < -64'sd2147483648) return 32'h80000000;
    return x64[31:0];
  endfunction

  // configuration registers
  logic [30:0] grav_q, tol_q;
  logic [7:0]  maxit_q;
  logic [7:0]  lim;

  state_e state_q, state_d;

  // request operands and working registers
  logic [W-1:0] head_q, flow_q, wid_q, h0_q, g2_q;
  logic [W-1:0] est_q, prior_q, a_q, c_q;
  logic [W-1:0] t1_q, t2_q, t3_q, t4_q;
  logic [7:0]   steps_q;
  status_e      status_q;
  logic [LW-1:0] lhs_q;
  logic          dz_q;

  // shared divider
  logic [NW-1:0]  dn_q;
  logic [W:0]     dr_q;
  logic [W-1:0]   dd_q;
  logic           dneg_q;
  logic [CNW-1:0] dcnt_q;
  logic [W:0]     rs;
  logic           ge;
  logic [W-1:0]   dq;

  // shared multiplier
  logic [W-1:0] ma, mb, mres;
  logic [W-1:0] dnum, dden;

  logic [W-1:0]  gw, fd;
  logic [W:0]    dsub, diff;
  logic [CW-1:0] rhs;
  logic          conv;

  assign lim = (maxit_q == 8'd0) ? 8'd1 : maxit_q;
  assign gw  = (64'(grav_q) > WMAX64) ? WMAX_W : W'(grav_q);

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      REG_GRAVITY: prdata = {1'b0, grav_q};
      REG_TOL:     prdata = {1'b0, tol_q};
      REG_MAXIT:   prdata = {24'd0, maxit_q};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q  <= GRAVITY_RESET;
      tol_q   <= TOL_RESET;
      maxit_q <= MAXIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_GRAVITY: grav_q  <= pwdata[30:0];
        REG_TOL:     tol_q   <= pwdata[30:0];
        REG_MAXIT:   maxit_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // pick multiplier operands for the current step
  always_comb begin
    ma = est_q;
    mb = est_q;
    unique case (state_q)
      S_B2:    begin ma = wid_q; mb = wid_q; end
      S_DEN:   begin ma = g2_q;  mb = t1_q;  end
      S_H02:   begin ma = h0_q;  mb = h0_q;  end
      S_QQ:    begin ma = flow_q; mb = flow_q; end
      S_AH:    begin ma = a_q;   mb = est_q; end
      S_H3:    begin ma = t1_q;  mb = est_q; end
      S_AH2:   begin ma = a_q;   mb = t1_q;  end
      default: ;
    endcase
  end
  assign mres = mul_fx(ma, mb);

  always_comb begin
    dnum = t3_q;
    dden = t4_q;
    unique case (state_q)
      S_CLD:   begin dnum = t3_q; dden = t1_q; end
      S_ALD:   begin dnum = c_q;  dden = t2_q; end
      default: ;
    endcase
  end

  // one restoring step per cycle; quotient bits shift in behind the numerator
  assign rs = {dr_q[W-1:0], dn_q[NW-1]};
  assign ge = rs >= {1'b0, dd_q};
  assign dq = sat_mag(MW'(dn_q), dneg_q);

  assign fd = add_s(add_s(add_s(t1_q, t1_q), t1_q), add_s(t2_q, t2_q));

  assign dsub = {est_q[W-1], est_q} - {prior_q[W-1], prior_q};
  assign diff = dsub[W] ? (~dsub + 1'b1) : dsub;
  assign rhs  = CW'(tol_q) * CW'(mag_f(est_q));
  assign conv = dz_q || ((est_q != '0) && (CW'(lhs_q) < rhs));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req_i.valid) state_d = S_B2;
      S_B2:    state_d = S_DEN;
      S_DEN:   state_d = S_H02;
      S_H02:   state_d = (t1_q == '0 || mres == '0) ? S_DONE : S_QQ;
      S_QQ:    state_d = S_CLD;
      S_CLD:   state_d = S_CRUN;
      S_CRUN:  if (dcnt_q == '0) state_d = S_ALD;
      S_ALD:   state_d = S_ARUN;
      S_ARUN:  if (dcnt_q == '0) state_d = S_ACO;
      S_ACO:   state_d = S_H2;
      S_H2:    state_d = S_AH;
      S_AH:    state_d = S_H3;
      S_H3:    state_d = S_AH2;
      S_AH2:   state_d = S_FSUM;
      S_FSUM:  state_d = S_NLD;
      S_NLD:   state_d = (t4_q == '0) ? S_DONE : S_NRUN;
      S_NRUN:  if (dcnt_q == '0) state_d = S_UPD;
      S_UPD:   state_d = S_CL;
      S_CL:    state_d = S_CR;
      S_CR:    state_d = (conv || steps_q >= lim) ? S_DONE : S_H2;
      S_DONE:  if (res_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      est_q    <= '0;
      prior_q  <= '0;
      a_q      <= '0;
      c_q      <= '0;
      steps_q  <= '0;
      status_q <= STAT_CONVERGED;
      dcnt_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: if (req_i.valid) begin
          // hold the operands and restart the estimate
          head_q  <= in_w(req_i.head);
          flow_q  <= in_w(req_i.flow);
          wid_q   <= in_w(req_i.width);
          h0_q    <= in_w(req_i.ref_depth);
          est_q   <= in_w(req_i.start_guess);
          prior_q <= in_w(req_i.start_guess);
          g2_q    <= add_s(gw, gw);
          steps_q <= '0;
          a_q     <= '0;
          c_q     <= '0;
        end
        S_B2:  t1_q <= mres;
        S_DEN: t1_q <= mres;
        S_H02: begin
          t2_q     <= mres;
          status_q <= STAT_ZERO_DIV;
        end
        S_QQ:  t3_q <= mres;
        S_CLD, S_ALD, S_NLD: begin
          dn_q   <= NW'(mag_f(dnum)) << F;
          dr_q   <= '0;
          dd_q   <= mag_f(dden);
          dneg_q <= dnum[W-1] ^ dden[W-1];
          dcnt_q <= CNW'(NW);
          if (state_q == S_NLD && t4_q == '0) status_q <= STAT_ZERO_DIV;
        end
        S_CRUN, S_ARUN, S_NRUN: begin
          if (dcnt_q != '0) begin
            dr_q   <= ge ? (rs - {1'b0, dd_q}) : rs;
            dn_q   <= {dn_q[NW-2:0], ge};
            dcnt_q <= dcnt_q - 1'b1;
          end else if (state_q == S_CRUN) begin
            c_q <= dq;
          end else begin
            t3_q <= dq;
          end
        end
        S_ACO: a_q <= sub_s(sub_s(head_q, t3_q), h0_q);
        S_H2:  t1_q <= mres;
        S_AH:  t2_q <= mres;
        S_H3:  t3_q <= mres;
        S_AH2: t4_q <= mres;
        S_FSUM: begin
          t3_q <= add_s(add_s(t3_q, t4_q), c_q);
          t4_q <= fd;
        end
        S_UPD: begin
          prior_q <= est_q;
          est_q   <= sub_s(est_q, t3_q);
          steps_q <= steps_q + 8'd1;
        end
        S_CL: begin
          lhs_q <= LW'(diff) * LW'(K100);
          dz_q  <= (diff == '0);
        end
        S_CR: status_q <= conv ? STAT_CONVERGED : STAT_LIMIT;
        default: ;
      endcase
    end
  end

  assign req_i.ready           = (state_q == S_IDLE);
  assign res_o.valid           = (state_q == S_DONE);
  assign res_o.root            = out32(est_q);
  assign res_o.iterations_used = steps_q;
  assign res_o.status          = status_q;

endmodule

// ----- hw/rtl/ncds_checker.sv -----
module ncds_checker
  import ncds_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [31:0] res_root_i,
  input logic [7:0]  res_iters_i,
  input logic [1:0]  res_status_i
);

  // no new item while a result waits
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !req_ready_i) else $error("ready high while result pending");

  a_busy_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i) else $error("ready right after accept");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(res_root_i)))
    else $error("stalled result changed");

  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_status_i == STAT_LIMIT) |-> (res_iters_i != 8'd0))
    else $error("limit status without a step");

endmodule

bind newton_cubic_depth_solver ncds_checker u_ncds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_root_i  (res_o.root),
  .res_iters_i (res_o.iterations_used),
  .res_status_i(res_o.status)
);
